// ===== hw/rtl/contiguous_block_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// Contiguous block allocator assertion macros
// Property shorthands for the allocator's checker.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define CBA_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBA_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cba_pkg.sv =====
// ---------------------------------------------------------------------------
// Contiguous block allocator package
// Field widths, reset values, request, status and register codes, sequencer states.
// ---------------------------------------------------------------------------
package cba_pkg;

  localparam int REQ_TYPE_W = 2;
  localparam int FILE_ID_W  = 6;
  localparam int NEW_SIZE_W = 23;
  localparam int STATUS_W   = 2;
  localparam int START_W    = 10;
  localparam int LEN_W      = 11;
  localparam int BB_W       = 13;
  localparam int BIU_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int WIDE_W     = 24;
  localparam int DIV_CNT_W  = 5;

  localparam logic [BB_W-1:0]  BB_RESET  = 13'd64;
  localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_CREATE,
    REQ_DELETE,
    REQ_TRUNCATE,
    REQ_LOOKUP
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_NOT_FOUND,
    ST_NO_SPACE,
    ST_EXISTS
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_BYTES,
    CFG_BLOCKS_IN_USE
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_LOOK,
    S_LOOKW,
    S_FREE,
    S_DIV,
    S_CMP,
    S_CHK,
    S_MARK,
    S_SUM,
    S_CSCAN,
    S_CPLACE,
    S_CFILL,
    S_DONE
  } state_t;

endpackage

// ===== hw/rtl/cba_ifs.sv =====
// ---------------------------------------------------------------------------
// Contiguous block allocator channels
// Request, response and configuration valid/ready interfaces.
// ---------------------------------------------------------------------------
interface cba_req_if;
  import cba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [FILE_ID_W-1:0]  file_id;
  logic [NEW_SIZE_W-1:0] new_size;
  modport source (output valid, req_type, file_id, new_size, input ready);
  modport sink   (input valid, req_type, file_id, new_size, output ready);
endinterface

interface cba_rsp_if;
  import cba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_block;
  logic [LEN_W-1:0]    length_blocks;
  logic                compacted;
  modport source (output valid, status, start_block, length_blocks, compacted, input ready);
  modport sink   (input valid, status, start_block, length_blocks, compacted, output ready);
endinterface

interface cba_cfg_if;
  import cba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cba_div.sv =====
// ---------------------------------------------------------------------------
// Contiguous block allocator divider
// Restoring divider, one quotient bit per cycle, for the block count.
// ---------------------------------------------------------------------------
module cba_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cba_pkg::NEW_SIZE_W-1:0] dividend,
  input  logic [cba_pkg::BB_W-1:0]       divisor,
  output logic                           done,
  output logic [cba_pkg::NEW_SIZE_W-1:0] quotient,
  output logic                           rem_nz
);
  import cba_pkg::*;

  logic [NEW_SIZE_W-1:0] quo;
  logic [BB_W-1:0]       rem;
  logic [BB_W-1:0]       dvs;
  logic [DIV_CNT_W-1:0]  cnt;
  logic                  busy;
  logic [BB_W:0]         shifted;
  logic [BB_W:0]         trial;

  assign shifted  = {rem, quo[NEW_SIZE_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = quo;
  assign rem_nz   = |rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= DIV_CNT_W'(NEW_SIZE_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (shifted >= {1'b0, dvs}) begin
          rem <= trial[BB_W-1:0];
          quo <= {quo[NEW_SIZE_W-2:0], 1'b1};
        end else begin
          rem <= shifted[BB_W-1:0];
          quo <= {quo[NEW_SIZE_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/contiguous_block_allocator.sv =====
// ---------------------------------------------------------------------------
// Contiguous block allocator
// Block bitmap and extent table with create, delete, truncate, lookup and compaction.
// ---------------------------------------------------------------------------
// Usage:
//   req : one item per request (req_type, file_id, new_size).
//   rsp : one item per request (status, start_block, length_blocks, compacted).
//   cfg : register writes (block_bytes, blocks_in_use), taken every cycle;
//         write only while no request is in flight.
//   One request at a time: req.ready is high only when the sequencer is idle.
//   Per request: lookup and requests on a missing or existing file read the
//   extent table and respond; create scans the bitmap for the first free
//   block, over all usable blocks when none is free; delete clears the extent's
//   bitmap bits. Truncate runs the divider, then a shrink frees the tail blocks
//   and growth in place marks the grown blocks. A failed in-place check adds
//   the free-count pass over the file table; compaction then runs one table
//   pass per moved file plus a final one, and a MAX_BLOCKS bitmap rewrite.
//   A new request can be taken in the cycle after a response is registered.
//   After reset a clearing pass zeroes all MAX_BLOCKS bitmap entries; no
//   request is taken until it ends. A stalled response is held in its output
//   register and the next request is still accepted meanwhile.
// ---------------------------------------------------------------------------
module contiguous_block_allocator #(
  parameter int MAX_BLOCKS = 1024,
  parameter int MAX_FILES  = 64
) (
  input logic       clk,
  input logic       rst,
  cba_req_if.sink   req,
  cba_rsp_if.source rsp,
  cba_cfg_if.sink   cfg
);
  import cba_pkg::*;

  localparam int AW  = $clog2(MAX_BLOCKS);
  localparam int LW  = $clog2(MAX_BLOCKS + 1);
  localparam int FW  = $clog2(MAX_FILES);
  localparam int FCW = $clog2(MAX_FILES + 1);
  localparam int CW  = (LW > FCW) ? LW : FCW;
  localparam int IW  = (FW > FILE_ID_W) ? FW : FILE_ID_W;

  state_t state, state_next;

  logic [BB_W-1:0]      block_bytes;
  logic [BIU_W-1:0]     blocks_in_use;
  logic [MAX_FILES-1:0] file_valid;

  logic          bm_mem [MAX_BLOCKS];
  logic          bm_rd;
  logic          bm_we;
  logic [AW-1:0] bm_waddr;
  logic          bm_wdata;
  logic [AW-1:0] bm_raddr;

  logic [AW-1:0] ext_st_mem  [MAX_FILES];
  logic [LW-1:0] ext_len_mem [MAX_FILES];
  logic [AW-1:0] ext_rd_st;
  logic [LW-1:0] ext_rd_len;
  logic          ext_we;
  logic [FW-1:0] ext_waddr;
  logic [AW-1:0] ext_wst;
  logic [LW-1:0] ext_wlen;
  logic [FW-1:0] ext_raddr;

  req_type_t         op;
  logic [IW-1:0]     id_q;
  logic [NEW_SIZE_W-1:0] size_q;
  logic [LW-1:0]     nb;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     lim;
  logic [CW-1:0]     pidx;
  logic              pend;
  logic              mark_val;
  logic [AW-1:0]     cur_st;
  logic [LW-1:0]     cur_len;
  logic              valid_q;
  status_t           status_q;
  logic              comp_q;
  logic [WIDE_W-1:0] need;
  logic [WIDE_W-1:0] others;
  logic [LW-1:0]     next_pos;
  logic [AW-1:0]     prev_st;
  logic              have_prev;
  logic              best_found;
  logic [FW-1:0]     best_idx;
  logic [AW-1:0]     best_st;
  logic [LW-1:0]     best_len;

  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [START_W-1:0]    out_start;
  logic [LEN_W-1:0]      out_len;
  logic                  out_comp;

  logic                  div_start;
  logic                  div_done;
  logic [NEW_SIZE_W-1:0] div_q;
  logic                  div_rem_nz;
  logic [BB_W-1:0]       div_dvs;

  logic [FW-1:0]     fidx;
  logic [FW-1:0]     pfile;
  logic [AW-1:0]     pblk;
  logic              scanning;
  logic              issue;
  logic              scan_end;
  logic [WIDE_W-1:0] st_w;
  logic [WIDE_W-1:0] len_w;
  logic [WIDE_W-1:0] nb_w;
  logic [WIDE_W-1:0] dq_w;
  logic [WIDE_W-1:0] need_calc;
  logic [LW-1:0]     nb_calc;
  logic              other_ok;
  logic              cand;
  logic              load;

  assign fidx      = id_q[FW-1:0];
  assign pfile     = pidx[FW-1:0];
  assign pblk      = pidx[AW-1:0];
  assign scanning  = (state == S_FREE) || (state == S_CHK) ||
                     (state == S_SUM) || (state == S_CSCAN);
  assign issue     = cnt < lim;
  assign scan_end  = !issue && !pend;
  assign st_w      = WIDE_W'(cur_st);
  assign len_w     = WIDE_W'(cur_len);
  assign nb_w      = WIDE_W'(nb);
  assign dq_w      = WIDE_W'(div_q) + WIDE_W'(div_rem_nz);
  assign need_calc = (dq_w == '0) ? WIDE_W'(1) : dq_w;
  assign nb_calc   = (WIDE_W'(blocks_in_use) > WIDE_W'(MAX_BLOCKS)) ?
                     LW'(MAX_BLOCKS) : LW'(blocks_in_use);
  assign other_ok  = file_valid[pfile] && (pfile != fidx);
  assign cand      = pend && other_ok && (!have_prev || (ext_rd_st > prev_st)) &&
                     (!best_found || (ext_rd_st < best_st));
  assign div_dvs   = (block_bytes == '0) ? BB_W'(1) : block_bytes;
  assign load      = (state == S_DONE) && (!out_valid || rsp.ready);

  cba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (size_q),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_rem_nz)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (cnt == CW'(MAX_BLOCKS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_MOD;
      end
      S_MOD: begin
        if (WIDE_W'(id_q) < WIDE_W'(MAX_FILES)) state_next = S_LOOK;
      end
      S_LOOK: state_next = S_LOOKW;
      S_LOOKW: begin
        case (op)
          REQ_CREATE:   state_next = file_valid[fidx] ? S_DONE : S_FREE;
          REQ_DELETE:   state_next = file_valid[fidx] ? S_MARK : S_DONE;
          REQ_TRUNCATE: state_next = file_valid[fidx] ? S_DIV : S_DONE;
          default:      state_next = S_DONE;
        endcase
      end
      S_FREE: begin
        if ((pend && !bm_rd) || scan_end) state_next = S_DONE;
      end
      S_DIV: begin
        if (div_done) state_next = S_CMP;
      end
      S_CMP: begin
        if (need < len_w) state_next = S_MARK;
        else if (need == len_w) state_next = S_DONE;
        else if (st_w + need > nb_w) state_next = S_SUM;
        else state_next = S_CHK;
      end
      S_CHK: begin
        if (pend && bm_rd) state_next = S_SUM;
        else if (scan_end) state_next = S_MARK;
      end
      S_MARK: begin
        if (!issue) state_next = S_DONE;
      end
      S_SUM: begin
        if (scan_end) state_next = (others + need <= nb_w) ? S_CSCAN : S_DONE;
      end
      S_CSCAN: begin
        if (scan_end) state_next = S_CPLACE;
      end
      S_CPLACE: state_next = best_found ? S_CSCAN : S_CFILL;
      S_CFILL: begin
        if (cnt == CW'(MAX_BLOCKS - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory write ports and divider start
  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = cnt[AW-1:0];
    bm_wdata  = 1'b0;
    ext_we    = 1'b0;
    ext_waddr = fidx;
    ext_wst   = cur_st;
    ext_wlen  = LW'(need);
    div_start = 1'b0;
    case (state)
      S_CLEAR: bm_we = 1'b1;
      S_LOOKW: div_start = (op == REQ_TRUNCATE) && file_valid[fidx];
      S_FREE: begin
        if (pend && !bm_rd) begin
          bm_we    = 1'b1;
          bm_waddr = pblk;
          bm_wdata = 1'b1;
          ext_we   = 1'b1;
          ext_wst  = pblk;
          ext_wlen = LW'(1);
        end
      end
      S_CMP: ext_we = need < len_w;
      S_CHK: ext_we = scan_end;
      S_MARK: begin
        bm_we    = issue;
        bm_wdata = mark_val;
      end
      S_CPLACE: begin
        ext_we = 1'b1;
        if (best_found) begin
          ext_waddr = best_idx;
          ext_wst   = AW'(next_pos);
          ext_wlen  = best_len;
        end else begin
          ext_wst = AW'(next_pos);
        end
      end
      S_CFILL: begin
        bm_we    = 1'b1;
        bm_wdata = issue;
      end
      default: ;
    endcase
  end

  assign bm_raddr  = cnt[AW-1:0];
  assign ext_raddr = (state == S_LOOK) ? fidx : cnt[FW-1:0];

  assign req.ready         = (state == S_IDLE);
  assign cfg.ready         = 1'b1;
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.start_block   = out_start;
  assign rsp.length_blocks = out_len;
  assign rsp.compacted     = out_comp;

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    bm_rd <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (ext_we) begin
      ext_st_mem[ext_waddr]  <= ext_wst;
      ext_len_mem[ext_waddr] <= ext_wlen;
    end
    ext_rd_st  <= ext_st_mem[ext_raddr];
    ext_rd_len <= ext_len_mem[ext_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      cnt           <= '0;
      pend          <= 1'b0;
      file_valid    <= '0;
      block_bytes   <= BB_RESET;
      blocks_in_use <= BIU_RESET;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.index))
          CFG_BLOCK_BYTES:   block_bytes   <= cfg.data[BB_W-1:0];
          CFG_BLOCKS_IN_USE: blocks_in_use <= cfg.data[BIU_W-1:0];
          default: ;
        endcase
      end

      pend <= scanning && issue;
      pidx <= cnt;
      if (scanning && issue) cnt <= cnt + 1'b1;

      case (state)
        S_CLEAR: cnt <= cnt + 1'b1;
        S_IDLE: begin
          if (req.valid) begin
            op     <= req_type_t'(req.req_type);
            id_q   <= IW'(req.file_id);
            size_q <= req.new_size;
            nb     <= nb_calc;
            comp_q <= 1'b0;
          end
        end
        S_MOD: begin
          if (WIDE_W'(id_q) >= WIDE_W'(MAX_FILES)) id_q <= id_q - IW'(MAX_FILES);
        end
        S_LOOKW: begin
          cur_st  <= ext_rd_st;
          cur_len <= ext_rd_len;
          valid_q <= file_valid[fidx];
          if (op == REQ_CREATE) status_q <= file_valid[fidx] ? ST_EXISTS : ST_OK;
          else status_q <= file_valid[fidx] ? ST_OK : ST_NOT_FOUND;
          if (op == REQ_DELETE && file_valid[fidx]) begin
            file_valid[fidx] <= 1'b0;
            valid_q          <= 1'b0;
          end
        end
        S_FREE: begin
          if (pend && !bm_rd) begin
            file_valid[fidx] <= 1'b1;
            valid_q          <= 1'b1;
            cur_st           <= pblk;
            cur_len          <= LW'(1);
          end else if (scan_end) begin
            status_q <= ST_NO_SPACE;
          end
        end
        S_DIV: begin
          if (div_done) need <= need_calc;
        end
        S_CMP: begin
          if (need < len_w) cur_len <= LW'(need);
        end
        S_CHK: begin
          if (scan_end) cur_len <= LW'(need);
        end
        S_MARK: begin
          if (issue) cnt <= cnt + 1'b1;
        end
        S_SUM: begin
          if (pend && other_ok) others <= others + WIDE_W'(ext_rd_len);
          if (scan_end && (others + need > nb_w)) status_q <= ST_NO_SPACE;
        end
        S_CSCAN: begin
          if (cand) begin
            best_found <= 1'b1;
            best_idx   <= pfile;
            best_st    <= ext_rd_st;
            best_len   <= ext_rd_len;
          end
        end
        S_CPLACE: begin
          if (best_found) begin
            next_pos  <= next_pos + best_len;
            prev_st   <= best_st;
            have_prev <= 1'b1;
          end else begin
            cur_st  <= AW'(next_pos);
            cur_len <= LW'(need);
            lim     <= CW'(next_pos) + CW'(LW'(need));
            comp_q  <= 1'b1;
          end
        end
        S_CFILL: cnt <= cnt + 1'b1;
        default: ;
      endcase

      // set up the loop of the state being entered
      if (state_next != state) begin
        case (state_next)
          S_FREE: begin
            cnt  <= '0;
            lim  <= CW'(nb);
            pend <= 1'b0;
          end
          S_CHK: begin
            cnt  <= CW'(cur_st) + CW'(cur_len);
            lim  <= CW'(st_w + need);
            pend <= 1'b0;
          end
          S_MARK: begin
            case (state)
              S_LOOKW: begin
                cnt      <= CW'(ext_rd_st);
                lim      <= CW'(ext_rd_st) + CW'(ext_rd_len);
                mark_val <= 1'b0;
              end
              S_CMP: begin
                cnt      <= CW'(st_w + need);
                lim      <= CW'(cur_st) + CW'(cur_len);
                mark_val <= 1'b0;
              end
              default: begin
                cnt      <= CW'(cur_st) + CW'(cur_len);
                lim      <= CW'(st_w + need);
                mark_val <= 1'b1;
              end
            endcase
          end
          S_SUM: begin
            cnt    <= '0;
            lim    <= CW'(MAX_FILES);
            pend   <= 1'b0;
            others <= '0;
          end
          S_CSCAN: begin
            cnt        <= '0;
            lim        <= CW'(MAX_FILES);
            pend       <= 1'b0;
            best_found <= 1'b0;
            if (state == S_SUM) begin
              next_pos  <= '0;
              have_prev <= 1'b0;
            end
          end
          S_CFILL: cnt <= '0;
          default: ;
        endcase
      end

      if (load) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= status_q;
      out_start  <= valid_q ? START_W'(cur_st) : '0;
      out_len    <= valid_q ? LEN_W'(cur_len) : '0;
      out_comp   <= comp_q;
    end
  end

endmodule

// ===== hw/rtl/cba_chk.sv =====
// ---------------------------------------------------------------------------
// Contiguous block allocator checker
// Port-level properties of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
`include "contiguous_block_allocator_defines.svh"

module cba_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cba_pkg::STATUS_W-1:0] out_status,
  input logic [cba_pkg::START_W-1:0]  out_start,
  input logic [cba_pkg::LEN_W-1:0]    out_len,
  input logic                         out_comp
);
  import cba_pkg::*;

  `CBA_ASSERT_NEXT(a_rsp_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_status), "response dropped or changed while stalled")
  `CBA_ASSERT_IMPL(a_missing_empty, clk, rst, out_valid && out_status == ST_NOT_FOUND, out_start == '0 && out_len == '0, "missing file reports an extent")
  `CBA_ASSERT_IMPL(a_comp_ok, clk, rst, out_valid && out_comp, out_status == ST_OK && out_len != '0, "compaction without a grown file")
  `CBA_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready, "second request taken while busy")
  `CBA_ASSERT_IMPL(a_exists_len, clk, rst, out_valid && out_status == ST_EXISTS, out_len != '0, "existing file reports no blocks")

endmodule

bind contiguous_block_allocator cba_chk u_cba_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_status (rsp.status),
  .out_start  (rsp.start_block),
  .out_len    (rsp.length_blocks),
  .out_comp   (rsp.compacted)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Contiguous block allocator testbench
// Named tests drive create, delete, truncate and lookup requests through the
// request channel. A model of the bitmap and extent table in the testbench
// predicts each response, which is checked field by field in arrival order.
// Register settings change only between phases, with random idling on both
// sides.
// ---------------------------------------------------------------------------
module tb;
  import cba_pkg::*;

  localparam int NBLK      = 1024;
  localparam int NFILE     = 64;
  localparam int CYC_LIMIT = 20000000;

  typedef struct packed {
    status_t            status;
    logic [START_W-1:0] start_block;
    logic [LEN_W-1:0]   length_blocks;
    logic               compacted;
  } alloc_rsp_t;

  logic clk;
  logic rst;

  cba_req_if req_ch ();
  cba_rsp_if rsp_ch ();
  cba_cfg_if cfg_ch ();

  contiguous_block_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // allocator shadow state
  bit              blk_used [NBLK];
  bit              slot_live [NFILE];
  int unsigned     ext_first [NFILE];
  int unsigned     ext_blocks [NFILE];
  logic [BB_W-1:0] bytes_per_blk;
  logic [BIU_W-1:0] store_blocks;

  alloc_rsp_t rsp_queue [$];
  int         n_errors;
  int         cycles;
  int         src_idle_pct;
  int         snk_stall_pct;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned usable_blocks();
    return (store_blocks > NBLK) ? NBLK : int'(store_blocks);
  endfunction

  function automatic void set_blocks(int unsigned from, int unsigned count, bit v);
    for (int unsigned i = 0; i < count; i++)
      if (from + i < NBLK) blk_used[from + i] = v;
  endfunction

  function automatic void compact_extents(int unsigned target, int unsigned newlen);
    int unsigned nxt;
    nxt = 0;
    for (int b = 0; b < NBLK; b++)
      for (int f = 0; f < NFILE; f++)
        if (slot_live[f] && f != target && ext_first[f] == b) begin
          ext_first[f] = nxt;
          nxt += ext_blocks[f];
        end
    ext_first[target] = nxt;
    ext_blocks[target] = newlen;
    for (int b = 0; b < NBLK; b++) blk_used[b] = 1'b0;
    set_blocks(0, nxt + newlen, 1'b1);
  endfunction

  function automatic alloc_rsp_t alloc_predict(req_type_t kind, int unsigned id,
                                               int unsigned sz);
    alloc_rsp_t  r;
    int unsigned nb, b, bb, need, st, len;
    longint unsigned others;
    bit          fits;
    nb = usable_blocks();
    r.status = ST_OK;
    r.compacted = 1'b0;
    case (kind)
      REQ_CREATE: begin
        if (slot_live[id]) begin
          r.status = ST_EXISTS;
        end else begin
          b = 0;
          while (b < nb && blk_used[b]) b++;
          if (b >= nb) begin
            r.status = ST_NO_SPACE;
          end else begin
            blk_used[b] = 1'b1;
            slot_live[id] = 1'b1;
            ext_first[id] = b;
            ext_blocks[id] = 1;
          end
        end
      end
      REQ_DELETE: begin
        if (!slot_live[id]) begin
          r.status = ST_NOT_FOUND;
        end else begin
          set_blocks(ext_first[id], ext_blocks[id], 1'b0);
          slot_live[id] = 1'b0;
        end
      end
      REQ_TRUNCATE: begin
        if (!slot_live[id]) begin
          r.status = ST_NOT_FOUND;
        end else begin
          bb = (bytes_per_blk == 0) ? 1 : int'(bytes_per_blk);
          need = sz / bb + ((sz % bb != 0) ? 1 : 0);
          st = ext_first[id];
          len = ext_blocks[id];
          if (need == 0) need = 1;
          if (need < len) begin
            set_blocks(st + need, len - need, 1'b0);
            ext_blocks[id] = need;
          end else if (need > len) begin
            fits = (longint'(st) + need <= nb);
            for (int unsigned i = st + len; fits && i < st + need; i++)
              if (blk_used[i]) fits = 1'b0;
            if (fits) begin
              set_blocks(st + len, need - len, 1'b1);
              ext_blocks[id] = need;
            end else begin
              others = 0;
              for (int f = 0; f < NFILE; f++)
                if (slot_live[f] && f != id) others += ext_blocks[f];
              if (others + need <= nb) begin
                compact_extents(id, need);
                r.compacted = 1'b1;
              end else begin
                r.status = ST_NO_SPACE;
              end
            end
          end
        end
      end
      default: begin
        if (!slot_live[id]) r.status = ST_NOT_FOUND;
      end
    endcase
    r.start_block   = slot_live[id] ? ext_first[id][START_W-1:0] : '0;
    r.length_blocks = slot_live[id] ? ext_blocks[id][LEN_W-1:0] : '0;
    return r;
  endfunction

  task automatic send_req(req_type_t kind, int unsigned id, int unsigned sz);
    int gap;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.file_id  <= id[FILE_ID_W-1:0];
    req_ch.new_size <= sz[NEW_SIZE_W-1:0];
    do @(posedge clk); while (!req_ch.ready);
    rsp_queue.push_back(alloc_predict(kind, id, sz));
  endtask

  task automatic drain_all();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (rsp_queue.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_BLOCK_BYTES) bytes_per_blk = val[BB_W-1:0];
    else store_blocks = val[BIU_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_config(int unsigned bb, int unsigned biu);
    write_reg(CFG_BLOCK_BYTES, bb);
    write_reg(CFG_BLOCKS_IN_USE, biu);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    alloc_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (rsp_queue.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected response item at cycle %0d", cycles);
      end else begin
        want = rsp_queue.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.start_block !== want.start_block ||
            rsp_ch.length_blocks !== want.length_blocks ||
            rsp_ch.compacted !== want.compacted) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp st=%0d sb=%0d len=%0d c=%0d got st=%0d sb=%0d len=%0d c=%0d",
                     want.status, want.start_block, want.length_blocks, want.compacted,
                     rsp_ch.status, rsp_ch.start_block, rsp_ch.length_blocks,
                     rsp_ch.compacted);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("[contiguous_block_allocator] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    send_req(REQ_LOOKUP, 5, 0);
    send_req(REQ_TRUNCATE, 5, 100);
    send_req(REQ_DELETE, 5, 0);
    send_req(REQ_CREATE, 0, 0);
    send_req(REQ_CREATE, 0, 0);
    send_req(REQ_LOOKUP, 0, 0);
    send_req(REQ_TRUNCATE, 0, 0);
    send_req(REQ_TRUNCATE, 0, 64 * 3 + 1);
    send_req(REQ_CREATE, 1, 0);
    send_req(REQ_TRUNCATE, 0, 640);
    send_req(REQ_TRUNCATE, 1, 23'h7FFFFF);
    send_req(REQ_TRUNCATE, 0, 64);
    send_req(REQ_DELETE, 0, 0);
    send_req(REQ_DELETE, 0, 0);
    send_req(REQ_CREATE, 63, 0);
    drain_all();
    set_config(0, 8);
    send_req(REQ_TRUNCATE, 1, 5);
    send_req(REQ_TRUNCATE, 63, 7);
    send_req(REQ_CREATE, 2, 0);
    drain_all();
    set_config(8191, 0);
    send_req(REQ_CREATE, 3, 0);
    send_req(REQ_TRUNCATE, 1, 8191 * 2);
    drain_all();
    set_config(4096, 2047);
    send_req(REQ_TRUNCATE, 63, 4194304);
    send_req(REQ_TRUNCATE, 1, 4096 * 3);
    send_req(REQ_DELETE, 63, 0);
    drain_all();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int bb, int biu, int n);
    int unsigned kind, id, sz, bbe, k, pick;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    set_config(bb, biu);
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    bbe = (bb == 0) ? 1 : bb;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_all();
      if ($urandom_range(99) < 85) begin
        pick = $urandom_range(99);
        kind = (pick < 30) ? REQ_CREATE : (pick < 45) ? REQ_DELETE :
               (pick < 90) ? REQ_TRUNCATE : REQ_LOOKUP;
        id = ($urandom_range(19) == 0) ? 63 : $urandom_range(11);
        k = $urandom_range(0, (usable_blocks() / 4) + 1);
        sz = k * bbe;
        if (sz > 0) sz = sz - $urandom_range(0, bbe - 1);
        if (sz > 23'h7FFFFF) sz = 23'h7FFFFF;
      end else begin
        kind = $urandom_range(3);
        id = $urandom_range(63);
        sz = $urandom & 23'h7FFFFF;
      end
      send_req(req_type_t'(kind), id, sz);
    end
    drain_all();
  endtask

  initial begin
    n_errors = 0;
    cycles = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    bytes_per_blk = BB_RESET;
    store_blocks = BIU_RESET;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_CREATE;
    req_ch.file_id <= '0;
    req_ch.new_size <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_BLOCK_BYTES;
    cfg_ch.data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(0, 0, 64, 1024, 60);
    test_random_phase(52, 0, 1, 16, 55);
    test_random_phase(0, 52, 4096, 40, 55);
    test_random_phase(14, 14, 8191, 2047, 55);
    test_random_phase(0, 0, 0, 1, 40);
    if (rsp_queue.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("[contiguous_block_allocator] OK");
    end else begin
      $display("[contiguous_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/cba_pkg.sv
hw/rtl/cba_ifs.sv
hw/rtl/cba_div.sv
hw/rtl/contiguous_block_allocator.sv
hw/rtl/cba_chk.sv
dv/tb.sv
